// ===== hdl/rational_function_evaluator_top_assert.svh =====
// Assertion macros shared by the rational function evaluator RTL.
`ifndef RATIONAL_FUNCTION_EVALUATOR_TOP_ASSERT_SVH
`define RATIONAL_FUNCTION_EVALUATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RFE_ASSERT_IMP(lbl, ante, cons, msg)

`define RFE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/rfe_pkg.sv =====
// Shared constants, word types and divider interface types of the rational function evaluator.
package rfe_pkg;

	localparam int unsigned MAX_TERMS = 16;
	localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
	localparam int unsigned TERMS_W = 5;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned PROD_W = 2 * VAL_W;
	localparam int unsigned SHR_W = PROD_W - FRAC_W;
	localparam int unsigned SUM_W = SHR_W + 1;
	localparam int unsigned DIVIDEND_W = VAL_W + FRAC_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIVIDEND_W + 1);
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL = 1'b1;
	localparam logic POLY_NUM = 1'b0;
	localparam logic POLY_DEN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEN_TERMS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY_ONLY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ZERO_DEN = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef struct packed {
		logic kind;
		logic which_poly;
		logic [3:0] coeff_index;
		logic signed [VAL_W-1:0] coeff_value;
		logic signed [VAL_W-1:0] x_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] y_value;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/rfe_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`include "rational_function_evaluator_top_assert.svh"

module rfe_div
	import rfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [VAL_W-1:0] dsr_q;

	logic [VAL_W:0] rem_sh;
	logic ge;
	logic [VAL_W:0] rem_sub;
	logic [VAL_W-1:0] rem_n;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		ge = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
		rem_n = ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign rsp = {busy_q, done_q, quo_q};

	`RFE_ASSERT_IMP(a_start_idle, req.start, !busy_q, "divider started while busy")
	`RFE_ASSERT_IMP(a_rem_bound, busy_q, (rem_q < dsr_q) || (dsr_q == '0), "remainder out of range")
	`RFE_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "stray divider done")

endmodule

// ===== hdl/rational_function_evaluator_top.sv =====
// Top level of the rational function evaluator: coefficient stores, Horner sequencer, output register.
//
// Input words arrive on in_valid/in_ready/in_data. A write word (kind 0) loads one numerator
// or denominator coefficient and yields no result. An evaluate word (kind 1)
// runs Horner's scheme over the numerator and then the denominator on one shared 32x32
// multiplier (per coefficient a multiply, then a shift, add and saturate), and then a
// bit-serial divider producing one of 48 quotient bits per cycle.
// In polynomial-only mode the denominator and the divider are skipped. The next word is
// accepted once the sequencer is idle again.
// Result words leave on out_valid/out_ready/out_data from an output register; the block takes
// further words while a result waits, and a finished evaluation holds until that register is
// free, so a stalled receiver loses nothing.
// Configuration words on cfg_valid/cfg_ready/cfg_index/cfg_data are always accepted and should
// only be sent while the block is idle.
// Reset clears both coefficient stores to zero, sets both term counts to one and selects the
// full quotient; no result is pending after reset.
`include "rational_function_evaluator_top_assert.svh"

module rational_function_evaluator_top
	import rfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TERMS_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_DIV,
		S_FINISH
	} state_t;

	function automatic logic [VAL_W:0] sat_val(input logic signed [SUM_W-1:0] v);
		logic ovf;
		logic [VAL_W-1:0] res;
		ovf = !((&v[SUM_W-1:VAL_W-1]) || !(|v[SUM_W-1:VAL_W-1]));
		if (ovf) begin
			res = v[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			res = v[VAL_W-1:0];
		end
		return {ovf, res};
	endfunction

	function automatic logic [VAL_W-1:0] abs_val(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

	state_t state_q;
	logic [TERMS_W-1:0] num_terms_q;
	logic [TERMS_W-1:0] den_terms_q;
	logic poly_only_q;

	logic [VAL_W-1:0] num_coef_q [MAX_TERMS];
	logic [VAL_W-1:0] den_coef_q [MAX_TERMS];

	logic signed [VAL_W-1:0] x_q;
	logic signed [VAL_W-1:0] acc_q;
	logic signed [VAL_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic phase_q;
	logic sat_q;
	logic neg_q;
	logic [VAL_W-1:0] res_q;
	logic [1:0] st_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [VAL_W-1:0] coef_s1;
	logic out_valid_q;
	out_word_t out_q;

	logic [CNT_W-1:0] nt;
	logic [CNT_W-1:0] dt;
	logic in_acc;
	logic coef_we;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] rd_idx;
	logic signed [SHR_W-1:0] prod_shr;
	logic signed [SUM_W-1:0] step_sum;
	logic [VAL_W:0] step_res;
	logic step_sat;
	logic signed [VAL_W-1:0] step_val;
	logic signed [SUM_W-1:0] quot_signed;
	logic [VAL_W:0] quot_res;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_comb begin
		nt = (int'(num_terms_q) > int'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(num_terms_q);
		dt = (int'(den_terms_q) > int'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(den_terms_q);
		in_acc = in_valid && in_ready;
		coef_we = in_acc && (in_data.kind == KIND_WRITE)
			&& (int'(in_data.coeff_index) < int'(MAX_TERMS));
		wr_idx = IDX_W'(in_data.coeff_index);
		rd_idx = IDX_W'(cnt_q - 1'b1);
		prod_shr = prod_s1[PROD_W-1:FRAC_W];
		step_sum = SUM_W'(prod_shr) + SUM_W'(coef_s1);
		step_res = sat_val(step_sum);
		step_sat = step_res[VAL_W];
		step_val = $signed(step_res[VAL_W-1:0]);
		quot_signed = neg_q ? -$signed(SUM_W'({1'b0, div_rsp.quotient}))
			: $signed(SUM_W'({1'b0, div_rsp.quotient}));
		quot_res = sat_val(quot_signed);
		div_req.start = (state_q == S_ADD) && (cnt_q == '0) && (phase_q == POLY_DEN)
			&& (step_val != '0);
		div_req.dividend = {abs_val(num_q), {FRAC_W{1'b0}}};
		div_req.divisor = abs_val(step_val);
	end

	rfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= TERMS_W'(1);
			den_terms_q <= TERMS_W'(1);
			poly_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_TERMS: num_terms_q <= cfg_data;
				CFG_DEN_TERMS: den_terms_q <= cfg_data;
				CFG_POLY_ONLY: poly_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(MAX_TERMS); i++) begin
				num_coef_q[i] <= '0;
				den_coef_q[i] <= '0;
			end
		end else if (coef_we) begin
			if (in_data.which_poly == POLY_NUM) begin
				num_coef_q[wr_idx] <= in_data.coeff_value;
			end else begin
				den_coef_q[wr_idx] <= in_data.coeff_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q <= '0;
			acc_q <= '0;
			num_q <= '0;
			cnt_q <= '0;
			phase_q <= POLY_NUM;
			sat_q <= 1'b0;
			neg_q <= 1'b0;
			res_q <= '0;
			st_q <= ST_OK;
			prod_s1 <= '0;
			coef_s1 <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.kind == KIND_EVAL)) begin
						x_q <= in_data.x_value;
						acc_q <= '0;
						sat_q <= 1'b0;
						phase_q <= POLY_NUM;
						if ((nt == '0) || (!poly_only_q && (dt == '0))) begin
							res_q <= '0;
							st_q <= ST_EMPTY;
							state_q <= S_FINISH;
						end else begin
							cnt_q <= nt;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_s1 <= PROD_W'(x_q) * PROD_W'(acc_q);
					coef_s1 <= (phase_q == POLY_NUM) ? num_coef_q[rd_idx] : den_coef_q[rd_idx];
					cnt_q <= cnt_q - 1'b1;
					state_q <= S_ADD;
				end
				S_ADD: begin
					sat_q <= sat_q | step_sat;
					if (cnt_q != '0) begin
						acc_q <= step_val;
						state_q <= S_MUL;
					end else if (phase_q == POLY_NUM) begin
						num_q <= step_val;
						if (poly_only_q) begin
							res_q <= step_val;
							st_q <= (sat_q | step_sat) ? ST_SAT : ST_OK;
							state_q <= S_FINISH;
						end else begin
							phase_q <= POLY_DEN;
							cnt_q <= dt;
							acc_q <= '0;
							state_q <= S_MUL;
						end
					end else if (step_val == '0) begin
						res_q <= '0;
						st_q <= ST_ZERO_DEN;
						state_q <= S_FINISH;
					end else begin
						neg_q <= num_q[VAL_W-1] ^ step_val[VAL_W-1];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_q <= quot_res[VAL_W-1:0];
						st_q <= (sat_q | quot_res[VAL_W]) ? ST_SAT : ST_OK;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q.y_value <= res_q;
						out_q.status <= st_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`RFE_ASSERT_IMP(a_err_zero, out_valid_q && ((out_q.status == ST_EMPTY) || (out_q.status == ST_ZERO_DEN)), out_q.y_value == '0, "error result carries a value")
	`RFE_ASSERT_NXT(a_eval_busy, in_acc && (in_data.kind == KIND_EVAL), !in_ready, "ready during evaluation")
	`RFE_ASSERT_IMP(a_idle_div, state_q == S_IDLE, !div_rsp.busy, "divider busy while idle")

endmodule
